// File: rtl/vsps_pkg.sv
// Shared types and constants for the visual-servo pick sequencer.
// Holds the beat structs, phase encoding, register indexes and saturation helper.
// No dependencies.
package vsps_pkg;

	typedef enum logic [1:0] {
		PH_FOLLOW  = 2'd0,
		PH_HOVER   = 2'd1,
		PH_DESCEND = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		REG_TARGET_X       = 3'd0,
		REG_TARGET_Y       = 3'd1,
		REG_GAIN           = 3'd2,
		REG_STEP_LIMIT     = 3'd3,
		REG_CAPTURE_WINDOW = 3'd4,
		REG_HOVER_TICKS    = 3'd5,
		REG_HOVER_STEP     = 3'd6
	} reg_index_t;

	localparam int CFG_DATA_W = 24;

	localparam logic [15:0] RST_TARGET_X       = 16'd6640;
	localparam logic [15:0] RST_TARGET_Y       = 16'd6880;
	localparam logic [15:0] RST_GAIN           = 16'd319;
	localparam logic [23:0] RST_STEP_LIMIT     = 24'd33554;
	localparam logic [15:0] RST_CAPTURE_WINDOW = 16'd48;
	localparam logic [15:0] RST_HOVER_TICKS    = 16'd700;
	localparam logic [23:0] RST_HOVER_STEP     = 24'd839;

	localparam logic signed [7:0] GRIP_OPEN  = -8'sd5;
	localparam logic signed [7:0] GRIP_CLOSE = 8'sd100;

	localparam logic [2:0] MASK_NONE    = 3'd0;
	localparam logic [2:0] MASK_HOVER   = 3'd3;
	localparam logic [2:0] MASK_DESCEND = 3'd4;
	localparam logic [2:0] MASK_FOLLOW  = 3'd7;

	typedef struct packed {
		logic        func;
		logic [7:0]  object_count;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
	} item_t;

	typedef struct packed {
		logic [1:0]         phase;
		logic signed [31:0] lr_command;
		logic signed [31:0] fb_command;
		logic signed [7:0]  gripper_command;
		logic [2:0]         sent_mask;
	} result_t;

	// signed 32-bit accumulate of a 25-bit signed delta, clamped to the 32-bit range
	function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
		input logic signed [24:0] delta);
		logic signed [32:0] sum;
		logic signed [31:0] res;
		sum = {acc[31], acc} + {{8{delta[24]}}, delta};
		if (sum[32] != sum[31]) begin
			res = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			res = sum[31:0];
		end
		return res;
	endfunction

endpackage

// File: rtl/visual_servo_pick_sequencer.sv
// Visual-servo pick sequencer: follow, hover and descend phases on a joint command set.
// Depends on vsps_pkg for beat structs, phase encoding and register indexes.
//
// Usage:
//   item channel (item_valid / item_stall / item) carries detections (func 0) and
//   timer ticks (func 1). Every accepted beat yields exactly one result beat on
//   result_valid / result_stall / result: phase after the step, the three held
//   joint commands and a mask of the commands issued by this beat.
//   Errors and the gain products are formed on the way into the first register;
//   clamp, sign selection and the saturating accumulate sit between it and the
//   state and result registers, from which result_valid comes. One beat is taken
//   every cycle while the result is not stalled.
//   A stalled result holds in its register; the first register then fills, after
//   which item_stall rises until the result is taken.
//   Configuration (cfg_we / cfg_index / cfg_data) must be written only while no
//   beat is in flight; the block does not enforce this. Indexes beyond six are ignored.
//   Reset loads the default setpoints, clears the commands and enters follow.
module visual_servo_pick_sequencer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  vsps_pkg::item_t                  item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output vsps_pkg::result_t                result,
	input  logic                             cfg_we,
	input  logic [2:0]                       cfg_index,
	input  logic [vsps_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [15:0] target_x_q, target_y_q, gain_q, window_q, hover_ticks_q;
	logic [23:0] step_limit_q, hover_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q    <= vsps_pkg::RST_TARGET_X;
			target_y_q    <= vsps_pkg::RST_TARGET_Y;
			gain_q        <= vsps_pkg::RST_GAIN;
			step_limit_q  <= vsps_pkg::RST_STEP_LIMIT;
			window_q      <= vsps_pkg::RST_CAPTURE_WINDOW;
			hover_ticks_q <= vsps_pkg::RST_HOVER_TICKS;
			hover_step_q  <= vsps_pkg::RST_HOVER_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				vsps_pkg::REG_TARGET_X:       target_x_q    <= cfg_data[15:0];
				vsps_pkg::REG_TARGET_Y:       target_y_q    <= cfg_data[15:0];
				vsps_pkg::REG_GAIN:           gain_q        <= cfg_data[15:0];
				vsps_pkg::REG_STEP_LIMIT:     step_limit_q  <= cfg_data;
				vsps_pkg::REG_CAPTURE_WINDOW: window_q      <= cfg_data[15:0];
				vsps_pkg::REG_HOVER_TICKS:    hover_ticks_q <= cfg_data[15:0];
				vsps_pkg::REG_HOVER_STEP:     hover_step_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// error, magnitude and gain product ahead of the first register
	logic signed [16:0] err_x, err_y;
	logic [15:0]        mag_x, mag_y;
	logic [31:0]        prod_x, prod_y;

	always_comb begin
		err_x  = $signed({1'b0, item.pos_x}) - $signed({1'b0, target_x_q});
		err_y  = $signed({1'b0, item.pos_y}) - $signed({1'b0, target_y_q});
		mag_x  = err_x[16] ? 16'(-err_x) : err_x[15:0];
		mag_y  = err_y[16] ? 16'(-err_y) : err_y[15:0];
		prod_x = mag_x * gain_q;
		prod_y = mag_y * gain_q;
	end

	logic        valid_s1, func_s1, one_obj_s1, win_s1;
	logic        neg_x_s1, nz_x_s1, neg_y_s1, nz_y_s1;
	logic [27:0] step_x_s1, step_y_s1;
	logic        item_accept, move_s1, out_free;

	assign out_free    = !result_valid || !result_stall;
	assign move_s1     = valid_s1 && out_free;
	assign item_stall  = valid_s1 && !out_free;
	assign item_accept = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_accept) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			func_s1    <= item.func;
			one_obj_s1 <= (item.object_count == 8'd1);
			win_s1     <= (mag_x < window_q) && (mag_y < window_q);
			neg_x_s1   <= err_x[16];
			nz_x_s1    <= (err_x != 17'sd0);
			neg_y_s1   <= err_y[16];
			nz_y_s1    <= (err_y != 17'sd0);
			step_x_s1  <= prod_x[31:4];
			step_y_s1  <= prod_y[31:4];
		end
	end

	// sequencer state
	vsps_pkg::phase_t   phase_q, phase_d;
	logic [15:0]        hover_cnt_q, hover_cnt_d, hover_inc;
	logic signed [31:0] lr_q, fb_q, lr_d, fb_d;
	logic signed [7:0]  grip_q, grip_d;
	logic [2:0]         mask_q, mask_d;
	logic               follow_hit, hover_hit, descend_hit, hover_done;
	logic [23:0]        clamp_x, clamp_y;
	logic signed [24:0] delta_x, delta_y;

	always_comb begin
		follow_hit  = !func_s1 && one_obj_s1 && (phase_q == vsps_pkg::PH_FOLLOW);
		hover_hit   = func_s1 && (phase_q == vsps_pkg::PH_HOVER);
		descend_hit = func_s1 && (phase_q == vsps_pkg::PH_DESCEND);
		hover_inc   = hover_cnt_q + 16'd1;
		hover_done  = (hover_inc == hover_ticks_q);
	end

	always_comb begin
		phase_d = phase_q;
		if (follow_hit && win_s1) begin
			phase_d = vsps_pkg::PH_HOVER;
		end else if (hover_hit && hover_done) begin
			phase_d = vsps_pkg::PH_DESCEND;
		end
	end

	always_comb begin
		clamp_x     = (step_x_s1 > {4'd0, step_limit_q}) ? step_limit_q : step_x_s1[23:0];
		clamp_y     = (step_y_s1 > {4'd0, step_limit_q}) ? step_limit_q : step_y_s1[23:0];
		delta_x     = neg_x_s1 ? -$signed({1'b0, clamp_x}) : $signed({1'b0, clamp_x});
		delta_y     = neg_y_s1 ? $signed({1'b0, clamp_y}) : -$signed({1'b0, clamp_y});
		lr_d        = lr_q;
		fb_d        = fb_q;
		grip_d      = grip_q;
		hover_cnt_d = hover_cnt_q;
		mask_d      = vsps_pkg::MASK_NONE;
		if (follow_hit) begin
			if (nz_y_s1) begin
				lr_d = vsps_pkg::sat_add(lr_q, delta_y);
			end
			if (nz_x_s1) begin
				fb_d = vsps_pkg::sat_add(fb_q, delta_x);
			end
			grip_d = vsps_pkg::GRIP_OPEN;
			mask_d = vsps_pkg::MASK_FOLLOW;
		end else if (hover_hit) begin
			fb_d        = vsps_pkg::sat_add(fb_q, $signed({1'b0, hover_step_q}));
			grip_d      = vsps_pkg::GRIP_OPEN;
			mask_d      = vsps_pkg::MASK_HOVER;
			hover_cnt_d = hover_done ? 16'd0 : hover_inc;
		end else if (descend_hit) begin
			grip_d = vsps_pkg::GRIP_CLOSE;
			mask_d = vsps_pkg::MASK_DESCEND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= vsps_pkg::PH_FOLLOW;
			hover_cnt_q  <= 16'd0;
			lr_q         <= 32'sd0;
			fb_q         <= 32'sd0;
			grip_q       <= 8'sd0;
			mask_q       <= vsps_pkg::MASK_NONE;
			result_valid <= 1'b0;
		end else begin
			if (move_s1) begin
				phase_q     <= phase_d;
				hover_cnt_q <= hover_cnt_d;
				lr_q        <= lr_d;
				fb_q        <= fb_d;
				grip_q      <= grip_d;
				mask_q      <= mask_d;
			end
			if (move_s1) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_comb begin
		result.phase           = phase_q;
		result.lr_command      = lr_q;
		result.fb_command      = fb_q;
		result.gripper_command = grip_q;
		result.sent_mask       = mask_q;
	end

	a_descend_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == vsps_pkg::PH_DESCEND |=> phase_q == vsps_pkg::PH_DESCEND)
		else $error("descend phase left");

	a_mask_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (mask_q == vsps_pkg::MASK_NONE || mask_q == vsps_pkg::MASK_HOVER ||
			mask_q == vsps_pkg::MASK_DESCEND || mask_q == vsps_pkg::MASK_FOLLOW))
		else $error("illegal sent mask");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!move_s1 |=> $stable(phase_q) && $stable(lr_q) && $stable(fb_q) && $stable(grip_q))
		else $error("state changed without a beat");

	a_hover_grip: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == vsps_pkg::PH_HOVER |-> grip_q == vsps_pkg::GRIP_OPEN)
		else $error("gripper not open in hover");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && result_valid)
		else $error("stall without held beat");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for visual_servo_pick_sequencer: follow, capture, hover and descend.
// Predicts every result beat from its own model of the sequencer and configuration.
// Depends on vsps_pkg for the beat structs, phase encoding and register indexes.
`timescale 1ns / 100ps

module testbench;

	localparam int          CYCLE_LIMIT = 1_000_000;
	localparam int          LONG_HOLD   = 300;
	localparam int          DRAIN_PAD   = 4;
	localparam logic [2:0]  REG_UNUSED  = 3'd7;
	localparam longint      CMD_MAX     = 64'sd2147483647;
	localparam longint      CMD_MIN     = -64'sd2147483648;

	logic                             clk          = 1'b0;
	logic                             arst_n       = 1'b0;
	logic                             item_valid   = 1'b0;
	logic                             item_stall;
	vsps_pkg::item_t                  item         = '0;
	logic                             result_valid;
	logic                             result_stall = 1'b0;
	vsps_pkg::result_t                result;
	logic                             cfg_we       = 1'b0;
	logic [2:0]                       cfg_index    = '0;
	logic [vsps_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

	// model copy of the register file
	logic [15:0]            set_x    = vsps_pkg::RST_TARGET_X;
	logic [15:0]            set_y    = vsps_pkg::RST_TARGET_Y;
	logic [15:0]            kp       = vsps_pkg::RST_GAIN;
	logic [23:0]            step_cap = vsps_pkg::RST_STEP_LIMIT;
	logic [15:0]            window   = vsps_pkg::RST_CAPTURE_WINDOW;
	logic [15:0]            n_ticks  = vsps_pkg::RST_HOVER_TICKS;
	logic [23:0]            tick_step = vsps_pkg::RST_HOVER_STEP;

	// model copy of the sequencer state
	vsps_pkg::phase_t       cur_phase  = vsps_pkg::PH_FOLLOW;
	logic [15:0]            tick_count = '0;
	logic signed [31:0]     lr_cmd     = '0;
	logic signed [31:0]     fb_cmd     = '0;
	logic signed [7:0]      grip_cmd   = '0;

	vsps_pkg::result_t      expected_results[$];
	int                     mismatches      = 0;
	int                     results_checked = 0;
	int                     beats_sent      = 0;
	int                     cycle_count     = 0;
	logic                   burst_mode      = 1'b0;
	logic                   hold_req        = 1'b0;

	visual_servo_pick_sequencer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic signed [31:0] clamp_add(input logic signed [31:0] acc,
		input longint delta);
		longint s;
		s = longint'(acc) + delta;
		if (s > CMD_MAX) s = CMD_MAX;
		if (s < CMD_MIN) s = CMD_MIN;
		return s[31:0];
	endfunction

	function automatic longint axis_step(input int mag);
		longint p;
		p = (longint'(mag) * longint'(kp)) >> 4;
		if (p > longint'(step_cap)) p = longint'(step_cap);
		return p;
	endfunction

	function automatic vsps_pkg::result_t servo_step(input vsps_pkg::item_t it);
		vsps_pkg::result_t r;
		int                ex, ey, mx, my;
		longint            sx, sy;
		logic [2:0]        sent;
		sent = vsps_pkg::MASK_NONE;
		if (it.func == 1'b0) begin
			if (it.object_count == 8'd1 && cur_phase == vsps_pkg::PH_FOLLOW) begin
				ex = int'(it.pos_x) - int'(set_x);
				ey = int'(it.pos_y) - int'(set_y);
				mx = (ex < 0) ? -ex : ex;
				my = (ey < 0) ? -ey : ey;
				sx = axis_step(mx);
				sy = axis_step(my);
				if (ey < 0) lr_cmd = clamp_add(lr_cmd, sy);
				if (ey > 0) lr_cmd = clamp_add(lr_cmd, -sy);
				if (ex > 0) fb_cmd = clamp_add(fb_cmd, sx);
				if (ex < 0) fb_cmd = clamp_add(fb_cmd, -sx);
				grip_cmd = vsps_pkg::GRIP_OPEN;
				sent = vsps_pkg::MASK_FOLLOW;
				if (mx < int'(window) && my < int'(window)) cur_phase = vsps_pkg::PH_HOVER;
			end
		end else if (cur_phase == vsps_pkg::PH_HOVER) begin
			tick_count = tick_count + 16'd1;
			fb_cmd = clamp_add(fb_cmd, longint'(tick_step));
			grip_cmd = vsps_pkg::GRIP_OPEN;
			sent = vsps_pkg::MASK_HOVER;
			if (tick_count == n_ticks) begin
				cur_phase = vsps_pkg::PH_DESCEND;
				tick_count = '0;
			end
		end else if (cur_phase == vsps_pkg::PH_DESCEND) begin
			grip_cmd = vsps_pkg::GRIP_CLOSE;
			sent = vsps_pkg::MASK_DESCEND;
		end
		r.phase = cur_phase;
		r.lr_command = lr_cmd;
		r.fb_command = fb_cmd;
		r.gripper_command = grip_cmd;
		r.sent_mask = sent;
		return r;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(0, 2);
		if (r < 95) return $urandom_range(3, 8);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [23:0] pick_value(input int width);
		logic [23:0] full;
		full = (24'd1 << width) - 24'd1;
		case ($urandom_range(0, 3))
			0: return '0;
			1: return full;
			default: return 24'($urandom) & full;
		endcase
	endfunction

	function automatic logic [15:0] near_value(input logic [15:0] t);
		int v;
		v = int'(t) + int'($urandom_range(0, 256)) - 128;
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return v[15:0];
	endfunction

	function automatic vsps_pkg::item_t detection(input logic [7:0] n, input logic [15:0] x,
		input logic [15:0] y);
		vsps_pkg::item_t it;
		it.func = 1'b0;
		it.object_count = n;
		it.pos_x = x;
		it.pos_y = y;
		return it;
	endfunction

	function automatic vsps_pkg::item_t timer_tick();
		vsps_pkg::item_t it;
		it.func = 1'b1;
		it.object_count = 8'($urandom);
		it.pos_x = 16'($urandom);
		it.pos_y = 16'($urandom);
		return it;
	endfunction

	function automatic vsps_pkg::item_t rand_item(input int tick_pct, input int near_pct);
		vsps_pkg::item_t it;
		it.func = ($urandom_range(0, 99) < tick_pct);
		it.object_count = ($urandom_range(0, 99) < 85) ? 8'd1 : 8'($urandom);
		if ($urandom_range(0, 99) < near_pct) begin
			it.pos_x = near_value(set_x);
			it.pos_y = near_value(set_y);
		end else begin
			it.pos_x = 16'($urandom);
			it.pos_y = 16'($urandom);
		end
		return it;
	endfunction

	task automatic send_item(input vsps_pkg::item_t it);
		int gap;
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		gap = burst_mode ? 0 : pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_ignored_items();
		send_item(detection(8'd0, 16'hFFFF, 16'h0000));
		send_item(detection(8'd2, 16'h1A00, 16'h1AE0));
		send_item(detection(8'd255, 16'h0000, 16'hFFFF));
		send_item(timer_tick());
		wait_drained();
	endtask

	task automatic test_register_writes();
		// high bits must drop: window becomes zero, so follow never ends here
		write_reg(vsps_pkg::REG_CAPTURE_WINDOW, 24'hFF0000);
		write_reg(vsps_pkg::REG_TARGET_X, 24'hA51234);
		write_reg(REG_UNUSED, 24'hFFFFFF);
		send_item(detection(8'd1, 16'h1234, 16'h0000));
		send_item(detection(8'd1, 16'h0000, 16'hFFFF));
		wait_drained();
	endtask

	task automatic test_follow_extremes();
		write_reg(vsps_pkg::REG_GAIN, 24'h00FFFF);
		write_reg(vsps_pkg::REG_STEP_LIMIT, 24'hFFFFFF);
		send_item(detection(8'd1, 16'h0000, 16'h0000));
		send_item(detection(8'd1, 16'hFFFF, 16'hFFFF));
		send_item(detection(8'd1, set_x, set_y));
		send_item(detection(8'd1, set_x, 16'h0000));
		wait_drained();
		write_reg(vsps_pkg::REG_GAIN, 24'h000000);
		send_item(detection(8'd1, 16'hFFFF, 16'h0000));
		wait_drained();
		write_reg(vsps_pkg::REG_GAIN, 24'h00FFFF);
		write_reg(vsps_pkg::REG_STEP_LIMIT, 24'h000000);
		send_item(detection(8'd1, 16'h0000, 16'hFFFF));
		wait_drained();
		write_reg(vsps_pkg::REG_STEP_LIMIT, 24'h000123);
		write_reg(vsps_pkg::REG_TARGET_X, 24'h000000);
		write_reg(vsps_pkg::REG_TARGET_Y, 24'h00FFFF);
		send_item(detection(8'd1, 16'h0000, 16'hFFFF));
		send_item(detection(8'd1, 16'hFFFF, 16'h0000));
		wait_drained();
	endtask

	task automatic test_saturation();
		write_reg(vsps_pkg::REG_STEP_LIMIT, 24'hFFFFFF);
		write_reg(vsps_pkg::REG_TARGET_X, 24'h000000);
		write_reg(vsps_pkg::REG_TARGET_Y, 24'h000000);
		repeat (135) send_item(detection(8'd1, 16'hFFFF, 16'hFFFF));
		wait_drained();
		write_reg(vsps_pkg::REG_TARGET_X, 24'h00FFFF);
		write_reg(vsps_pkg::REG_TARGET_Y, 24'h00FFFF);
		repeat (262) send_item(detection(8'd1, 16'h0000, 16'h0000));
		wait_drained();
	endtask

	task automatic test_follow_random();
		logic [15:0] ticks_pick;
		repeat (6) begin
			case ($urandom_range(0, 2))
				0: ticks_pick = 16'd1;
				1: ticks_pick = 16'hFFFF;
				default: ticks_pick = 16'($urandom_range(1, 65535));
			endcase
			write_reg(vsps_pkg::REG_TARGET_X, pick_value(16));
			write_reg(vsps_pkg::REG_TARGET_Y, pick_value(16));
			write_reg(vsps_pkg::REG_GAIN, pick_value(16));
			write_reg(vsps_pkg::REG_STEP_LIMIT, ($urandom_range(0, 1)) ? pick_value(24) :
				24'($urandom_range(0, 4096)));
			write_reg(vsps_pkg::REG_HOVER_TICKS, {8'h00, ticks_pick});
			write_reg(vsps_pkg::REG_HOVER_STEP, pick_value(24));
			repeat (20) send_item(rand_item(5, 40));
			wait_drained();
		end
	endtask

	task automatic test_backpressure();
		write_reg(vsps_pkg::REG_TARGET_X, 24'h001A00);
		write_reg(vsps_pkg::REG_TARGET_Y, 24'h001AE0);
		write_reg(vsps_pkg::REG_GAIN, 24'h00013F);
		write_reg(vsps_pkg::REG_STEP_LIMIT, 24'h008312);
		hold_req = 1'b1;
		burst_mode = 1'b1;
		repeat (24) send_item(rand_item(0, 50));
		burst_mode = 1'b0;
		// hold the sender until every beat is back
		wait_drained();
	endtask

	task automatic test_capture();
		write_reg(vsps_pkg::REG_TARGET_X, 24'h0003E8);
		write_reg(vsps_pkg::REG_TARGET_Y, 24'h0007D0);
		write_reg(vsps_pkg::REG_CAPTURE_WINDOW, 24'h000040);
		send_item(detection(8'd2, 16'd1000, 16'd2000));
		send_item(detection(8'd1, 16'd1064, 16'd2000));
		send_item(detection(8'd1, 16'd936, 16'd2010));
		send_item(detection(8'd1, 16'd1063, 16'd1937));
		wait_drained();
	endtask

	task automatic test_hover();
		write_reg(vsps_pkg::REG_HOVER_TICKS, 24'h01000A);
		write_reg(vsps_pkg::REG_HOVER_STEP, pick_value(24));
		repeat (5) begin
			send_item(timer_tick());
			send_item(detection(8'd1, 16'($urandom), 16'($urandom)));
		end
		wait_drained();
		// zero ticks: keep advancing, the count cannot match before it wraps
		write_reg(vsps_pkg::REG_HOVER_TICKS, 24'h000000);
		write_reg(vsps_pkg::REG_HOVER_STEP, 24'hFFFFFF);
		repeat (40) send_item(rand_item(60, 30));
		wait_drained();
		burst_mode = 1'b1;
		repeat (60) send_item(timer_tick());
		burst_mode = 1'b0;
		wait_drained();
		write_reg(vsps_pkg::REG_HOVER_TICKS, {8'h00, 16'(tick_count + 16'd20)});
		write_reg(vsps_pkg::REG_HOVER_STEP, 24'($urandom));
		burst_mode = 1'b1;
		while (cur_phase != vsps_pkg::PH_DESCEND) send_item(timer_tick());
		burst_mode = 1'b0;
		wait_drained();
	endtask

	task automatic test_descend();
		repeat (30) send_item(rand_item(50, 30));
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (cfg_we) begin
			case (cfg_index)
				vsps_pkg::REG_TARGET_X:       set_x = cfg_data[15:0];
				vsps_pkg::REG_TARGET_Y:       set_y = cfg_data[15:0];
				vsps_pkg::REG_GAIN:           kp = cfg_data[15:0];
				vsps_pkg::REG_STEP_LIMIT:     step_cap = cfg_data[23:0];
				vsps_pkg::REG_CAPTURE_WINDOW: window = cfg_data[15:0];
				vsps_pkg::REG_HOVER_TICKS:    n_ticks = cfg_data[15:0];
				vsps_pkg::REG_HOVER_STEP:     tick_step = cfg_data[23:0];
				default: ;
			endcase
		end
		if (item_valid && !item_stall) begin
			expected_results.push_back(servo_step(item));
			beats_sent++;
		end
	end

	always @(posedge clk) begin : check_results
		vsps_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result beat: phase %0d lr %0d fb %0d grip %0d mask %0d",
						result.phase, result.lr_command, result.fb_command,
						result.gripper_command, result.sent_mask);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (result.phase !== want.phase || result.lr_command !== want.lr_command ||
					result.fb_command !== want.fb_command ||
					result.gripper_command !== want.gripper_command ||
					result.sent_mask !== want.sent_mask) begin
					if (mismatches < 10)
						$display({"result %0d (expected/actual): phase %0d/%0d lr %0d/%0d ",
							"fb %0d/%0d grip %0d/%0d mask %0d/%0d"}, results_checked,
							want.phase, result.phase, want.lr_command, result.lr_command,
							want.fb_command, result.fb_command, want.gripper_command,
							result.gripper_command, want.sent_mask, result.sent_mask);
					mismatches++;
				end
			end
		end
	end

	initial begin : receiver
		int n;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				for (n = 0; n < LONG_HOLD; n++) @(posedge clk);
				result_stall <= 1'b0;
			end else if (!burst_mode && $urandom_range(0, 99) < 30) begin
				n = pick_gap() + 1;
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_ignored_items();
		test_register_writes();
		test_follow_extremes();
		test_saturation();
		test_follow_random();
		test_backpressure();
		test_capture();
		test_hover();
		test_descend();
		wait_drained();
		repeat (8) @(posedge clk);
		$display("Covered ignored beats, follow with saturation, capture, hover with a zero");
		$display("tick count and descend, under random gaps and a long receiver hold.");
		$display("%0d beats sent, %0d results checked, %0d mismatches.", beats_sent,
			results_checked, mismatches);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
